[rtl/rtot_pkg.sv]
// rtot_pkg: shared types and constants for the retransmit timeout table
// no dependencies; imported by every module of the block
`default_nettype none

package rtot_pkg;

    localparam int ENTRIES = 64;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIM_W   = 26;           // rtt (16 bits) times 256 + loss (10 bits)
    localparam int CMP_W   = 32 + 7;       // elapsed scaled by 128

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACK,
        S_TICK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] sequence_req;
        logic [31:0] payload_tag;
        logic [31:0] now_ms;
        logic [15:0] rtt_ms;
        logic [8:0]  loss_q8;
    } t_in;

    typedef struct packed {
        logic [15:0] resend_sequence;
        logic [31:0] resend_payload;
        logic [7:0]  attempt;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] payload;
        logic [31:0] tx_stamp;
        logic [7:0]  retries;
    } t_entry;

    // control handed from the sequencer to the head evaluator
    typedef struct packed {
        logic             ack_mode;
        logic             tick_mode;
        logic             found;
        logic [15:0]      req_seq;
        logic [31:0]      now;
        logic [LIM_W-1:0] limit;
    } t_head_ctl;

    typedef struct packed {
        logic hit;
        logic due;
    } t_head_res;

endpackage

`default_nettype wire

[rtl/rtot_cell.sv]
// rtot_cell: one table entry of the rotating chain
// depends on rtot_pkg (t_entry)
`default_nettype none

module rtot_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire logic            i_load,
    input  rtot_pkg::t_entry     i_load_entry,
    input  rtot_pkg::t_entry     i_next,
    output rtot_pkg::t_entry     o_entry
);
    import rtot_pkg::*;

    logic [15:0] r_seq;
    logic [31:0] r_payload;
    logic [31:0] r_tx_stamp;
    logic [7:0]  r_retries;

    // only the sequence field is cleared: zero marks the entry empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (i_load) begin
            r_seq <= i_load_entry.seq;
        end else if (i_shift) begin
            r_seq <= i_next.seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_payload  <= i_load_entry.payload;
            r_tx_stamp <= i_load_entry.tx_stamp;
            r_retries  <= i_load_entry.retries;
        end else if (i_shift) begin
            r_payload  <= i_next.payload;
            r_tx_stamp <= i_next.tx_stamp;
            r_retries  <= i_next.retries;
        end
    end

    assign o_entry.seq      = r_seq;
    assign o_entry.payload  = r_payload;
    assign o_entry.tx_stamp = r_tx_stamp;
    assign o_entry.retries  = r_retries;

endmodule

`default_nettype wire

[rtl/rtot_head.sv]
// rtot_head: evaluates the entry at the head of the chain during a scan
// depends on rtot_pkg (t_entry, t_head_ctl, t_head_res)
`default_nettype none

module rtot_head (
    input  rtot_pkg::t_head_ctl  i_ctl,
    input  rtot_pkg::t_entry     i_entry,
    output rtot_pkg::t_entry     o_entry,
    output rtot_pkg::t_head_res  o_res
);
    import rtot_pkg::*;

    logic [31:0]      elapsed;
    logic [CMP_W-1:0] scaled;
    logic             live;

    assign elapsed = i_ctl.now - i_entry.tx_stamp;
    assign scaled  = {elapsed, 7'b0};
    assign live    = (i_entry.seq != '0);

    // elapsed*256 > 2*limit, both sides halved
    assign o_res.due = i_ctl.tick_mode && live
                       && (scaled > {{(CMP_W-LIM_W){1'b0}}, i_ctl.limit});
    assign o_res.hit = i_ctl.ack_mode && !i_ctl.found && (i_entry.seq == i_ctl.req_seq);

    always_comb begin
        o_entry = i_entry;
        if (o_res.hit) begin
            o_entry.seq = '0;
        end else if (o_res.due) begin
            o_entry.tx_stamp = i_ctl.now;
            if (i_entry.retries != 8'hFF) begin
                o_entry.retries = i_entry.retries + 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/retransmit_timeout_table_unit.sv]
// retransmit_timeout_table_unit: top level, sequencer and output staging
// depends on rtot_pkg, rtot_cell, rtot_head
`default_nettype none

// Table of sent packets waiting for acknowledgement, held as a ring of
// ENTRIES cells that rotate one place per cycle during a scan. A store
// transfer writes the entry straight into the cell at the write slot and
// the slot advances, overwriting the oldest entry. An ack is accepted and
// then rotates the whole ring once before the next transfer is taken. A
// tick rotates the ring the same way and then hands the last resend to the
// output; the head cell is evaluated on each step. On top of that a tick
// stalls for every cycle in which a newly found resend meets both the
// holding register and the output register full, and for every cycle the
// final resend waits for the downstream side. Resends come out in slot order;
// the final one of a tick carries last. The output register lets the next
// item be accepted while a result still waits. The sequence field of every
// cell clears at reset; other fields are written before they are read.

module retransmit_timeout_table_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  rtot_pkg::t_in   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output rtot_pkg::t_out  o_data
);
    import rtot_pkg::*;

    // sequencer state
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_count, n_count;
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic              r_found, n_found;
    logic [15:0]       r_req_seq, n_req_seq;
    logic [31:0]       r_now, n_now;
    logic [LIM_W-1:0]  r_limit, n_limit;

    // resend held back until we know whether it is the last of the tick
    logic              r_pend_valid, n_pend_valid;
    t_out              r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              shift;
    logic              load;
    t_entry            load_entry;
    t_entry            cells [ENTRIES];
    t_entry            head_out;
    t_head_ctl         head_ctl;
    t_head_res         head_res;
    logic [9:0]        loss_c;
    logic [LIM_W-1:0]  prod;
    logic              out_free;

    // clamp loss to 1.0, then rtt*(256+loss); the factor 2 sits in the compare
    assign loss_c = (i_data.loss_q8 > 9'd256) ? 10'd512 : (10'd256 + {1'b0, i_data.loss_q8});
    assign prod   = LIM_W'({10'b0, i_data.rtt_ms} * {16'b0, loss_c});

    assign load_entry.seq      = i_data.sequence_req;
    assign load_entry.payload  = i_data.payload_tag;
    assign load_entry.tx_stamp = i_data.now_ms;
    assign load_entry.retries  = 8'd0;

    // ring of cells: each takes its upper neighbor, the top one takes the head result
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        t_entry next_entry;
        if (k == ENTRIES - 1) begin : g_wrap
            assign next_entry = head_out;
        end else begin : g_link
            assign next_entry = cells[k+1];
        end
        rtot_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_load       (load && (r_wslot == SLOT_W'(k))),
            .i_load_entry (load_entry),
            .i_next       (next_entry),
            .o_entry      (cells[k])
        );
    end

    assign head_ctl.ack_mode  = (r_state == S_ACK);
    assign head_ctl.tick_mode = (r_state == S_TICK);
    assign head_ctl.found     = r_found;
    assign head_ctl.req_seq   = r_req_seq;
    assign head_ctl.now       = r_now;
    assign head_ctl.limit     = r_limit;

    rtot_head u_head (
        .i_ctl   (head_ctl),
        .i_entry (cells[0]),
        .o_entry (head_out),
        .o_res   (head_res)
    );

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_wslot      <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_wslot      <= n_wslot;
            r_found      <= n_found;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req_seq <= n_req_seq;
        r_now     <= n_now;
        r_limit   <= n_limit;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_wslot      = r_wslot;
        n_found      = r_found;
        n_req_seq    = r_req_seq;
        n_now        = r_now;
        n_limit      = r_limit;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        shift        = 1'b0;
        load         = 1'b0;
        o_ready      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_data.opcode)
                        OP_STORE: begin
                            load = 1'b1;
                            if (r_wslot == SLOT_W'(ENTRIES - 1)) begin
                                n_wslot = '0;
                            end else begin
                                n_wslot = r_wslot + SLOT_W'(1);
                            end
                        end
                        OP_ACK: begin
                            n_state   = S_ACK;
                            n_count   = '0;
                            n_found   = 1'b0;
                            n_req_seq = i_data.sequence_req;
                        end
                        OP_TICK: begin
                            n_state = S_TICK;
                            n_count = '0;
                            n_now   = i_data.now_ms;
                            n_limit = prod;
                        end
                        default: begin
                            // unused opcode: no effect
                        end
                    endcase
                end
            end
            S_ACK: begin
                shift   = 1'b1;
                n_found = r_found || head_res.hit;
                n_count = r_count + SLOT_W'(1);
                if (r_count == SLOT_W'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                // stall only when a second resend needs the busy output
                if (!(head_res.due && r_pend_valid && !out_free)) begin
                    shift = 1'b1;
                    if (head_res.due) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out.last  = 1'b0;
                        end
                        n_pend_valid           = 1'b1;
                        n_pend.resend_sequence = cells[0].seq;
                        n_pend.resend_payload  = cells[0].payload;
                        n_pend.attempt         = head_out.retries;
                        n_pend.last            = 1'b0;
                    end
                    n_count = r_count + SLOT_W'(1);
                    if (r_count == SLOT_W'(ENTRIES - 1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[test/tb.sv]
// tb: self-checking testbench for retransmit_timeout_table_unit
// depends on rtot_pkg and the retransmit_timeout_table_unit rtl, nothing else

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtot_pkg::*;

    // opcode with no meaning to the block, must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_AT      = 40;      // transfers accepted before the long stall
    localparam int HOLD_CYCLES  = 400;     // long downstream stall
    localparam int DRAIN_CYCLES = 200;     // idle time after the last resend is back
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_OPS   = 90;
    localparam int SAT_TICKS    = 258;     // enough to drive a retry count to its saturation at 255
    localparam int MAX_REPORTS  = 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_item  = '0;

    // output channel
    logic out_valid;
    logic rx_ready = 1'b0;
    t_out out_item;

    // stimulus and expected resends
    t_in  pending_ops [$];
    t_out due_resends [$];

    int unsigned total_ops      = 0;
    int unsigned ops_accepted   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;

    // shadow copy of the packet table
    logic [15:0] tbl_seq     [ENTRIES];
    logic [31:0] tbl_payload [ENTRIES];
    logic [31:0] tbl_time    [ENTRIES];
    logic [7:0]  tbl_retries [ENTRIES];
    int unsigned wr_slot;

    retransmit_timeout_table_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_item),
        .o_valid (out_valid),
        .i_ready (rx_ready),
        .o_data  (out_item)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // idle rates by thirds of the run: sender light / receiver heavy, swapped, none
    function automatic int unsigned tx_idle_pct();
        if (ops_accepted * 3 < total_ops)
            return 29;
        else if (ops_accepted * 3 < total_ops * 2)
            return 65;
        else
            return 0;
    endfunction

    function automatic int unsigned rx_idle_pct();
        if (ops_accepted * 3 < total_ops)
            return 65;
        else if (ops_accepted * 3 < total_ops * 2)
            return 29;
        else
            return 0;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_op(input logic [1:0] op, input logic [31:0] seq,
                            input logic [31:0] tag, input logic [31:0] now,
                            input logic [31:0] rtt, input logic [31:0] loss);
        t_in item;
        item.opcode       = op;
        item.sequence_req = seq[15:0];
        item.payload_tag  = tag;
        item.now_ms       = now;
        item.rtt_ms       = rtt[15:0];
        item.loss_q8      = loss[8:0];
        pending_ops.push_back(item);
    endtask

    // apply one accepted transfer to the shadow table, queue the resends it causes
    task automatic predict_table_op(input t_in item);
        logic [63:0] limit;
        logic [63:0] loss;
        logic [31:0] elapsed;
        logic        hit;
        bit          due [ENTRIES];
        int          n_due;
        int          k;
        t_out        res;
        hit   = 1'b0;
        n_due = 0;
        k     = 0;
        case (item.opcode)
            OP_STORE: begin
                tbl_seq[wr_slot]     = item.sequence_req;
                tbl_payload[wr_slot] = item.payload_tag;
                tbl_time[wr_slot]    = item.now_ms;
                tbl_retries[wr_slot] = 8'd0;
                wr_slot = (wr_slot == ENTRIES - 1) ? 0 : wr_slot + 1;
            end
            OP_ACK: begin
                // only the lowest matching slot is cleared
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!hit && tbl_seq[i] == item.sequence_req) begin
                        tbl_seq[i] = 16'd0;
                        hit = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                // loss above one counts as one
                loss  = (item.loss_q8 > 9'd256) ? 64'd256 : {55'd0, item.loss_q8};
                limit = 64'd2 * {48'd0, item.rtt_ms} * (64'd256 + loss);
                for (int i = 0; i < ENTRIES; i++) begin
                    due[i] = 1'b0;
                    if (tbl_seq[i] != 16'd0) begin
                        elapsed = item.now_ms - tbl_time[i];   // wraps in 32 bits
                        if (({32'd0, elapsed} << 8) > limit) begin
                            due[i] = 1'b1;
                            n_due++;
                        end
                    end
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (due[i]) begin
                        tbl_time[i] = item.now_ms;
                        if (tbl_retries[i] != 8'hFF)
                            tbl_retries[i] = tbl_retries[i] + 8'd1;
                        res.resend_sequence = tbl_seq[i];
                        res.resend_payload  = tbl_payload[i];
                        res.attempt         = tbl_retries[i];
                        res.last            = (k == n_due - 1);
                        due_resends.push_back(res);
                        k++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_resend(input t_out got);
        t_out want;
        if (due_resends.size() == 0) begin
            log_mismatch($sformatf("unexpected resend seq %h payload %h attempt %0d",
                                   got.resend_sequence, got.resend_payload, got.attempt));
        end else begin
            want = due_resends.pop_front();
            if (got.resend_sequence !== want.resend_sequence)
                log_mismatch($sformatf("resend_sequence got %h want %h",
                                       got.resend_sequence, want.resend_sequence));
            if (got.resend_payload !== want.resend_payload)
                log_mismatch($sformatf("resend_payload got %h want %h (seq %h)",
                                       got.resend_payload, want.resend_payload,
                                       want.resend_sequence));
            if (got.attempt !== want.attempt)
                log_mismatch($sformatf("attempt got %0d want %0d (seq %h)",
                                       got.attempt, want.attempt, want.resend_sequence));
            if (got.last !== want.last)
                log_mismatch($sformatf("last got %b want %b (seq %h)",
                                       got.last, want.last, want.resend_sequence));
        end
    endtask

    // driver: offers queued transfers, predicts each one as it is accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                predict_table_op(in_item);
                ops_accepted <= ops_accepted + 1;
            end
            // valid only changes once the current transfer is gone
            if (!in_valid || in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_ops.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes resends, compares against the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (out_valid && rx_ready)
                check_resend(out_item);
            // one long stall early on so the output backs up into the input
            if (!hold_done && ops_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rx_ready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rx_ready  <= 1'b0;
            end else begin
                rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d resends still due",
                 cycle_count, due_resends.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] clock_ms;
        logic [15:0] seq;
        logic [15:0] recent [$];
        int          random_ops;
        int          pick;
        int          burst;
        int          live_slot;

        for (int i = 0; i < ENTRIES; i++) begin
            tbl_seq[i]     = 16'd0;
            tbl_payload[i] = 32'd0;
            tbl_time[i]    = 32'd0;
            tbl_retries[i] = 8'd0;
        end
        wr_slot = 0;

        // directed: tick on an empty table
        queue_op(OP_TICK, $urandom, $urandom, $urandom, 16'd0, 9'd0);
        // field extremes, a non-live store and a duplicated sequence
        queue_op(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom);
        queue_op(OP_STORE, 16'h0001, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom);
        queue_op(OP_STORE, 16'h0000, $urandom, 32'd100, $urandom, $urandom);
        queue_op(OP_STORE, 16'h1234, $urandom, 32'd50, $urandom, $urandom);
        queue_op(OP_STORE, 16'h1234, $urandom, 32'd60, $urandom, $urandom);
        // ack of a duplicated sequence clears only the lower slot
        queue_op(OP_ACK, 16'h1234, $urandom, $urandom, $urandom, $urandom);
        // zero timeout, all live entries due
        queue_op(OP_TICK, $urandom, $urandom, 32'd200, 16'd0, 9'd0);
        // same time again, zero elapsed is not due
        queue_op(OP_TICK, $urandom, $urandom, 32'd200, 16'd0, 9'd0);
        // elapsed exactly at the timeout is not due
        queue_op(OP_TICK, $urandom, $urandom, 32'd300, 16'd50, 9'd0);
        // loss above one clamped, one ms past the timeout
        queue_op(OP_TICK, $urandom, $urandom, 32'd301, 16'd25, 9'h1FF);
        // elapsed across the time wrap
        queue_op(OP_STORE, 16'h8000, 32'hA5A5_A5A5, 32'hFFFF_FFF0, $urandom, $urandom);
        queue_op(OP_TICK, $urandom, $urandom, 32'h0000_0020, 16'd0, 9'd256);
        // largest rtt and loss against half the time range
        queue_op(OP_TICK, $urandom, $urandom, 32'h8000_0020, 16'hFFFF, 9'd256);
        queue_op(OP_ACK, 16'hFFFF, $urandom, $urandom, $urandom, $urandom);
        queue_op(OP_ACK, 16'h0001, $urandom, $urandom, $urandom, $urandom);
        // ack with no match, ack of zero
        queue_op(OP_ACK, 16'h7777, $urandom, $urandom, $urandom, $urandom);
        queue_op(OP_ACK, 16'h0000, $urandom, $urandom, $urandom, $urandom);
        // unused opcode with every field bit set
        queue_op(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 9'h1FF);

        // random: stores, acks of recent sequences, ticks, occasional noise
        clock_ms   = $urandom;
        random_ops = 0;
        while (random_ops < RANDOM_OPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst; b++) begin
                    clock_ms = clock_ms + $urandom_range(0, 40);
                    if ($urandom_range(0, 9) == 0)
                        seq = 16'd0;
                    else if ($urandom_range(0, 4) == 0 && recent.size() != 0)
                        seq = recent[$urandom_range(0, recent.size() - 1)];
                    else
                        seq = 16'($urandom_range(1, 65535));
                    queue_op(OP_STORE, seq, $urandom, clock_ms, $urandom, $urandom);
                    recent.push_back(seq);
                    if (recent.size() > 24)
                        void'(recent.pop_front());
                    random_ops++;
                end
            end else if (pick < 55) begin
                if ($urandom_range(0, 9) < 7 && recent.size() != 0)
                    seq = recent[$urandom_range(0, recent.size() - 1)];
                else if ($urandom_range(0, 3) == 0)
                    seq = 16'd0;
                else
                    seq = 16'($urandom);
                queue_op(OP_ACK, seq, $urandom, $urandom, $urandom, $urandom);
                random_ops++;
            end else if (pick < 95) begin
                // mostly short steps so some entries are due and some not
                if (pick < 90)
                    clock_ms = clock_ms + $urandom_range(0, 600);
                else
                    clock_ms = clock_ms + $urandom;
                queue_op(OP_TICK, $urandom, $urandom, clock_ms,
                         ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
                                                     : $urandom_range(0, 256));
                random_ops++;
            end else begin
                queue_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end

        // retry saturation: refill the ring with one live entry, then tick it until its retries stop at 255
        live_slot = $urandom_range(0, ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            clock_ms = clock_ms + $urandom_range(0, 5);
            queue_op(OP_STORE, (i == live_slot) ? $urandom_range(1, 65535) : 32'd0,
                     $urandom, clock_ms, $urandom, $urandom);
        end
        for (int i = 0; i < SAT_TICKS; i++) begin
            clock_ms = clock_ms + $urandom_range(1, 500);
            queue_op(OP_TICK, $urandom, $urandom, clock_ms, 16'd0, $urandom);
        end

        total_ops = pending_ops.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // everything accepted, then every resend back, then let the block settle
        while (ops_accepted != total_ops)
            @(posedge clk);
        while (due_resends.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && due_resends.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/rtot_pkg.sv
rtl/rtot_cell.sv
rtl/rtot_head.sv
rtl/retransmit_timeout_table_unit.sv
test/tb.sv
